// ----- rtl/assert_macros.svh -----
// Assertion helper macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

// ----- rtl/csa_pkg.sv -----
// ----------------------------------------------------------------------------
// csa_pkg
// Shared types and constants of the cosine similarity accumulator.
// ----------------------------------------------------------------------------
package csa_pkg;
  localparam int ElemBits = 16;
  localparam int AccBits  = 48;
  localparam int ProdBits = 2 * AccBits;
  localparam int RootBits = AccBits + 1;
  localparam int NumBits  = AccBits + 15;

  typedef enum logic [2:0] {
    StIdle, StMul, StRoot, StDiv, StOut
  } state_e;

  typedef struct packed {
    logic acc_en;
    logic clear;
    logic mul_start;
    logic root_start;
    logic root_step;
    logic div_start;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic root_done;
    logic div_done;
    logic zero;
  } sts_t;
endpackage

// ----- rtl/csa_datapath.sv -----
// ----------------------------------------------------------------------------
// csa_datapath
// Accumulators, multi-cycle product, bitwise root and restoring divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module csa_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  csa_pkg::cmd_t           cmd_i,
  output csa_pkg::sts_t           sts_o,
  input  logic [15:0]             elem_a_i,
  input  logic [15:0]             elem_b_i,
  output logic [15:0]             similarity_o,
  output logic                    zero_vector_o
);
  import csa_pkg::*;

  logic signed [AccBits-1:0] dot_q, dot_d;
  logic [AccBits-1:0] sa_q, sa_d, sb_q, sb_d;
  logic signed [ElemBits-1:0] ea, eb;
  logic signed [2*ElemBits-1:0] pab;
  logic [2*ElemBits-1:0] paa, pbb;
  logic signed [AccBits:0] dsum;
  logic [AccBits:0] asum, bsum;

  assign ea  = elem_a_i[ElemBits-1:0];
  assign eb  = elem_b_i[ElemBits-1:0];
  assign pab = ea * eb;
  assign paa = unsigned'((2*ElemBits)'(ea) * (2*ElemBits)'(ea));
  assign pbb = unsigned'((2*ElemBits)'(eb) * (2*ElemBits)'(eb));
  assign dsum = {dot_q[AccBits-1], dot_q} + (AccBits+1)'(pab);
  assign asum = {1'b0, sa_q} + (AccBits+1)'(paa);
  assign bsum = {1'b0, sb_q} + (AccBits+1)'(pbb);

  always_comb begin
    dot_d = dot_q;
    sa_d  = sa_q;
    sb_d  = sb_q;
    if (cmd_i.clear) begin
      dot_d = '0;
      sa_d  = '0;
      sb_d  = '0;
    end else if (cmd_i.acc_en) begin
      if (dsum[AccBits] != dsum[AccBits-1]) begin
        dot_d = dsum[AccBits] ? {1'b1, {(AccBits-1){1'b0}}} : {1'b0, {(AccBits-1){1'b1}}};
      end else begin
        dot_d = dsum[AccBits-1:0];
      end
      sa_d = asum[AccBits] ? '1 : asum[AccBits-1:0];
      sb_d = bsum[AccBits] ? '1 : bsum[AccBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      sa_q  <= '0;
      sb_q  <= '0;
    end else begin
      dot_q <= dot_d;
      sa_q  <= sa_d;
      sb_q  <= sb_d;
    end
  end

  // 48x48 product in nine 16x16 partial products, one per cycle.
  logic [3:0] mcnt_q;
  logic [ProdBits-1:0] prod_q;
  logic [15:0] ma, mb;
  logic [31:0] pp;
  logic [6:0] sh;
  always_comb begin
    case (mcnt_q)
      4'd0, 4'd1, 4'd2: ma = sa_q[15:0];
      4'd3, 4'd4, 4'd5: ma = sa_q[31:16];
      default:          ma = sa_q[47:32];
    endcase
    case (mcnt_q)
      4'd0, 4'd3, 4'd6: mb = sb_q[15:0];
      4'd1, 4'd4, 4'd7: mb = sb_q[31:16];
      default:          mb = sb_q[47:32];
    endcase
    case (mcnt_q)
      4'd0:             sh = 7'd0;
      4'd1, 4'd3:       sh = 7'd16;
      4'd2, 4'd4, 4'd6: sh = 7'd32;
      4'd5, 4'd7:       sh = 7'd48;
      default:          sh = 7'd64;
    endcase
  end
  assign pp = ma * mb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q <= 4'd9;
    end else if (cmd_i.mul_start) begin
      mcnt_q <= '0;
    end else if (mcnt_q != 4'd9) begin
      mcnt_q <= mcnt_q + 4'd1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      prod_q <= '0;
    end else if (mcnt_q != 4'd9) begin
      prod_q <= prod_q + (ProdBits'(pp) << sh);
    end
  end

  // Digit-by-digit root: one bit per cycle while root_step is set, remainder form.
  logic [ProdBits-1:0] rrem_q, rrem_d, rsrc_q;
  logic [RootBits-1:0] root_q;
  logic [5:0] rcnt_q;
  logic [ProdBits+1:0] rtrial, racc;
  assign racc   = {rrem_q, rsrc_q[ProdBits-1:ProdBits-2]};
  assign rtrial = racc - {{(ProdBits-RootBits-1){1'b0}}, root_q, 2'b01};
  assign rrem_d = rtrial[ProdBits+1] ? racc[ProdBits-1:0] : rtrial[ProdBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcnt_q <= '0;
    end else if (cmd_i.root_start) begin
      rcnt_q <= 6'd48;
    end else if (cmd_i.root_step && rcnt_q != 6'd0) begin
      rcnt_q <= rcnt_q - 6'd1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.root_start) begin
      rrem_q <= '0;
      rsrc_q <= prod_q;
      root_q <= '0;
    end else if (cmd_i.root_step && rcnt_q != 6'd0) begin
      rrem_q <= rrem_d;
      rsrc_q <= rsrc_q << 2;
      root_q <= {root_q[RootBits-2:0], ~rtrial[ProdBits+1]};
    end
  end

  // Restoring divide of |dot|<<15 by root, one quotient bit per cycle while div_step is set.
  logic [NumBits-1:0] num_q;
  logic [RootBits:0] drem_q, dtry;
  logic [RootBits:0] dsub;
  logic [6:0] dcnt_q;
  logic neg_q;
  logic [AccBits-1:0] mag;
  assign mag  = dot_q[AccBits-1] ? AccBits'(-dot_q) : AccBits'(dot_q);
  assign dtry = {drem_q[RootBits-1:0], num_q[NumBits-1]};
  assign dsub = dtry - {1'b0, root_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= 7'(NumBits);
    end else if (cmd_i.div_step && dcnt_q != 7'd0) begin
      dcnt_q <= dcnt_q - 7'd1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_q  <= {mag, 15'd0};
      drem_q <= '0;
      neg_q  <= dot_q[AccBits-1];
    end else if (cmd_i.div_step && dcnt_q != 7'd0) begin
      num_q  <= {num_q[NumBits-2:0], ~dsub[RootBits]};
      drem_q <= dsub[RootBits] ? dtry : dsub;
    end
  end

  logic zero;
  assign zero = (sa_q == '0) || (sb_q == '0);

  always_comb begin
    if (zero) begin
      similarity_o = '0;
    end else if (!neg_q) begin
      similarity_o = (num_q > NumBits'(32767)) ? 16'sd32767 : num_q[15:0];
    end else begin
      similarity_o = (num_q > NumBits'(32768)) ? 16'h8000 : 16'(-num_q[15:0]);
    end
  end
  assign zero_vector_o = zero;

  assign sts_o.mul_done  = (mcnt_q == 4'd9);
  assign sts_o.root_done = (rcnt_q == 6'd0);
  assign sts_o.div_done  = (dcnt_q == 7'd0);
  assign sts_o.zero      = zero;

  `ASSERT_IMPL(a_root_start, clk_i, rst_ni, cmd_i.root_start |=> rcnt_q == 6'd48, "root count")
  `ASSERT_IMPL(a_div_start, clk_i, rst_ni, cmd_i.div_start |=> !sts_o.div_done, "div start")
  `ASSERT_IMPL(a_clear, clk_i, rst_ni, cmd_i.clear |=> sts_o.zero, "clear")
endmodule

// ----- rtl/csa_ctrl.sv -----
// ----------------------------------------------------------------------------
// csa_ctrl
// Sequencer for accumulate, product, root, divide and result handoff.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module csa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          last_elem_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output csa_pkg::cmd_t cmd_o,
  input  csa_pkg::sts_t sts_i
);
  import csa_pkg::*;

  state_e state_q, state_d;
  logic acc;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (acc && last_elem_i) state_d = StMul;
      StMul: begin
        if (sts_i.zero) state_d = StOut;
        else if (sts_i.mul_done) state_d = StRoot;
      end
      StRoot: if (sts_i.root_done) state_d = StDiv;
      StDiv:  if (sts_i.div_done) state_d = StOut;
      StOut:  if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o  = (state_q == StIdle);
    out_valid_o = (state_q == StOut);
    unique case (state_q)
      StIdle: begin
        cmd_o.acc_en    = acc;
        cmd_o.mul_start = acc && last_elem_i;
      end
      StMul:  cmd_o.root_start = sts_i.mul_done && !sts_i.zero;
      StRoot: begin
        cmd_o.root_step = 1'b1;
        cmd_o.div_start = sts_i.root_done;
      end
      StDiv:  cmd_o.div_step = 1'b1;
      StOut:  cmd_o.clear = out_ready_i;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "out drop")
  `ASSERT_IMPL(a_no_in, clk_i, rst_ni, out_valid_o |-> !in_ready_o, "in while out")
  `ASSERT_IMPL(a_last, clk_i, rst_ni, acc && last_elem_i |=> state_q == StMul, "last")
endmodule

// ----- rtl/cosine_similarity_accumulator.sv -----
// After the last pair the product, root and divide steps run in that order
// before the result is valid.
// Throughput: one pair per cycle within a vector; the back end holds input off.
// A zero vector skips root and divide and is reported straight from the product state.
// Reset clears the sums and returns the sequencer to idle.
// ----------------------------------------------------------------------------
// cosine_similarity_accumulator
// Streaming cosine similarity of two Q1.15 vectors.
// ----------------------------------------------------------------------------
module cosine_similarity_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] elem_a_i,
  input  logic [15:0] elem_b_i,
  input  logic        last_elem_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] similarity_o,
  output logic        zero_vector_o
);
  import csa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  csa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .last_elem_i,
    .out_valid_o, .out_ready_i, .cmd_o(cmd), .sts_i(sts)
  );

  csa_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .elem_a_i, .elem_b_i,
    .similarity_o, .zero_vector_o
  );
endmodule
